FILE: sv/wpc_pkg.sv
package wpc_pkg;

    // Payload words
    typedef struct packed {
        logic [15:0] half_plate_a_angle;
        logic [15:0] quarter_plate_a_angle;
        logic [15:0] half_plate_b_angle;
        logic [15:0] quarter_plate_b_angle;
    } t_in_item;

    typedef struct packed {
        logic [29:0] horizontal_intensity;
        logic [29:0] vertical_intensity;
    } t_out_item;

    // Widths of the internal fixed-point values
    localparam int unsigned CS_W   = 19;  // Q1.17 cos/sin, holds +-2^17
    localparam int unsigned VEC_W  = 34;  // Q.30 vector component with headroom
    localparam int unsigned CRD_W  = 34;  // CORDIC x, y, z
    localparam int unsigned CORDIC_STEPS = 28;

    typedef struct packed {
        logic signed [CS_W-1:0] c;
        logic signed [CS_W-1:0] s;
    } t_cs;

    typedef struct packed {
        logic signed [VEC_W-1:0] ar;
        logic signed [VEC_W-1:0] ai;
        logic signed [VEC_W-1:0] br;
        logic signed [VEC_W-1:0] bi;
    } t_vec;

    localparam logic signed [63:0] Q17_ONE     = 64'sd131072;
    localparam logic signed [63:0] Q30_ONE     = 64'sd1073741824;
    localparam logic signed [63:0] HALF_PI_Q30 = 64'sd1686629713;
    localparam logic signed [63:0] CORDIC_GAIN = 64'sd652032874;
    localparam logic [63:0]        OUT_MAX     = 64'd1073741823;
    localparam logic [63:0]        SCALE_FULL  = 64'd10000;
    localparam logic [63:0]        SCALE_UNIT  = 64'd100;

    localparam logic signed [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
        32'sh3243F6A8, 32'sh1DAC6705, 32'sh0FADBAFC, 32'sh07F56EA6, 32'sh03FEAB76,
        32'sh01FFD55B, 32'sh00FFFAAA, 32'sh007FFF55, 32'sh003FFFEA, 32'sh001FFFFD,
        32'sh000FFFFF, 32'sh0007FFFF, 32'sh0003FFFF, 32'sh0001FFFF, 32'sh0000FFFF,
        32'sh00007FFF, 32'sh00003FFF, 32'sh00001FFF, 32'sh00000FFF, 32'sh000007FF,
        32'sh000003FF, 32'sh000001FF, 32'sh000000FF, 32'sh0000007F, 32'sh0000003F,
        32'sh0000001F, 32'sh0000000F, 32'sh00000008
    };

    // Shift right by n, rounding half away from zero
    function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                   input int unsigned n);
        logic signed [63:0] h;
        h = 64'sd1 <<< (n - 1);
        if (v < 0) begin
            return (v + h - 64'sd1) >>> n;
        end
        return (v + h) >>> n;
    endfunction

    // Limit to +-1.0 in Q1.17
    function automatic logic signed [CS_W-1:0] clamp17(input logic signed [63:0] v);
        if (v > Q17_ONE) begin
            return CS_W'(Q17_ONE);
        end
        if (v < -Q17_ONE) begin
            return CS_W'(-Q17_ONE);
        end
        return CS_W'(v);
    endfunction

endpackage

FILE: sv/wpc_cordic.sv
module wpc_cordic
    import wpc_pkg::*;
#(
    parameter int ANGLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  logic [15:0] i_angle,
    output logic        o_vld,
    output t_cs         o_cs
);

    localparam int SH = 33 - ANGLE_BITS;

    logic [47:0]        w_ext;
    logic [31:0]        w_p;
    logic [32:0]        w_rnd;
    logic signed [63:0] w_r;

    logic                   r_vld [CORDIC_STEPS+3];
    logic [1:0]             r_q   [CORDIC_STEPS+3];
    logic signed [63:0]     r_prod;
    logic signed [CRD_W-1:0] r_x  [CORDIC_STEPS+1];
    logic signed [CRD_W-1:0] r_y  [CORDIC_STEPS+1];
    logic signed [CRD_W-1:0] r_z  [CORDIC_STEPS+1];
    t_cs                    r_cs;

    // Double the angle, split off the quadrant, center the remainder
    assign w_ext = 48'({32'd0, i_angle}) << SH;
    assign w_p   = w_ext[31:0];
    assign w_rnd = {1'b0, w_p} + 33'd536870912;
    assign w_r   = $signed({34'd0, w_rnd[29:0]}) - 64'sd536870912;

    // Valid bits and quadrant travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CORDIC_STEPS + 3; i++) r_vld[i] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
            for (int i = 1; i < CORDIC_STEPS + 3; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_q[0] <= w_rnd[31:30];
        for (int i = 1; i < CORDIC_STEPS + 3; i++) r_q[i] <= r_q[i-1];
    end

    // Scale remainder to radians
    always_ff @(posedge i_clk) begin
        r_prod <= w_r * HALF_PI_Q30;
        r_z[0] <= CRD_W'(rnd_shr(r_prod, 30));
        r_x[0] <= CRD_W'(CORDIC_GAIN);
        r_y[0] <= '0;
    end

    // One rotation per stage
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (r_z[k] >= 0) begin
                r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                r_z[k+1] <= r_z[k] - CRD_W'(ATAN_Q30[k]);
            end else begin
                r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                r_z[k+1] <= r_z[k] + CRD_W'(ATAN_Q30[k]);
            end
        end
    end

    // Map back to the quadrant, round to Q1.17 and clamp
    always_ff @(posedge i_clk) begin
        logic signed [63:0] x, y, cq, sq;
        x = 64'(r_x[CORDIC_STEPS]);
        y = 64'(r_y[CORDIC_STEPS]);
        unique case (r_q[CORDIC_STEPS+1])
            2'd0:    begin cq = x;  sq = y;  end
            2'd1:    begin cq = -y; sq = x;  end
            2'd2:    begin cq = -x; sq = -y; end
            default: begin cq = y;  sq = -x; end
        endcase
        r_cs.c <= clamp17(rnd_shr(cq, 13));
        r_cs.s <= clamp17(rnd_shr(sq, 13));
    end

    assign o_vld = r_vld[CORDIC_STEPS+2];
    assign o_cs  = r_cs;

endmodule

FILE: sv/wpc_half_plate.sv
module wpc_half_plate
    import wpc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_vld,
    input  t_cs  i_cs,
    input  t_vec i_vec,
    output logic o_vld,
    output t_vec o_vec
);

    logic               r_vld [2];
    logic signed [63:0] r_m   [8];
    t_vec               r_vec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
            r_vld[1] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
            r_vld[1] <= r_vld[0];
        end
    end

    // Form the products
    always_ff @(posedge i_clk) begin
        r_m[0] <= 64'(i_cs.c) * 64'(i_vec.ar);
        r_m[1] <= 64'(i_cs.s) * 64'(i_vec.br);
        r_m[2] <= 64'(i_cs.c) * 64'(i_vec.ai);
        r_m[3] <= 64'(i_cs.s) * 64'(i_vec.bi);
        r_m[4] <= 64'(i_cs.s) * 64'(i_vec.ar);
        r_m[5] <= 64'(i_cs.c) * 64'(i_vec.br);
        r_m[6] <= 64'(i_cs.s) * 64'(i_vec.ai);
        r_m[7] <= 64'(i_cs.c) * 64'(i_vec.bi);
    end

    // Sum and round back to Q.30
    always_ff @(posedge i_clk) begin
        r_vec.ar <= VEC_W'(rnd_shr(r_m[0] + r_m[1], 17));
        r_vec.ai <= VEC_W'(rnd_shr(r_m[2] + r_m[3], 17));
        r_vec.br <= VEC_W'(rnd_shr(r_m[4] - r_m[5], 17));
        r_vec.bi <= VEC_W'(rnd_shr(r_m[6] - r_m[7], 17));
    end

    assign o_vld = r_vld[1];
    assign o_vec = r_vec;

endmodule

FILE: sv/wpc_quarter_plate.sv
module wpc_quarter_plate
    import wpc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_vld,
    input  t_cs  i_cs,
    input  t_vec i_vec,
    output logic o_vld,
    output t_vec o_vec
);

    logic               r_vld [2];
    logic signed [63:0] r_p [4];
    logic signed [63:0] r_n [4];
    logic signed [63:0] r_h [4];
    logic signed [63:0] w_pf, w_mf, w_hf;
    logic signed [63:0] w_v [4];
    t_vec               r_vec;

    // P = 1+C, M = 1-C, H = S, all over 2 in Q.18
    assign w_pf = Q17_ONE + 64'(i_cs.c);
    assign w_mf = Q17_ONE - 64'(i_cs.c);
    assign w_hf = 64'(i_cs.s);
    assign w_v[0] = 64'(i_vec.ar);
    assign w_v[1] = 64'(i_vec.ai);
    assign w_v[2] = 64'(i_vec.br);
    assign w_v[3] = 64'(i_vec.bi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
            r_vld[1] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
            r_vld[1] <= r_vld[0];
        end
    end

    // Form the products, one per coefficient and component
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_p[i] <= w_pf * w_v[i];
            r_n[i] <= w_mf * w_v[i];
            r_h[i] <= w_hf * w_v[i];
        end
    end

    // Sum and round back to Q.30
    always_ff @(posedge i_clk) begin
        r_vec.ar <= VEC_W'(rnd_shr(r_p[0] - r_n[1] + r_h[2] + r_h[3], 18));
        r_vec.ai <= VEC_W'(rnd_shr(r_p[1] + r_n[0] + r_h[3] - r_h[2], 18));
        r_vec.br <= VEC_W'(rnd_shr(r_h[0] + r_h[1] + r_n[2] - r_p[3], 18));
        r_vec.bi <= VEC_W'(rnd_shr(r_h[1] - r_h[0] + r_n[3] + r_p[2], 18));
    end

    assign o_vld = r_vld[1];
    assign o_vec = r_vec;

endmodule

FILE: sv/wpc_intensity.sv
module wpc_intensity
    import wpc_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_vld,
    input  logic      i_mode,
    input  t_vec      i_vec,
    output logic      o_vld,
    output t_out_item o_item
);

    localparam logic [63:0] CAP_FULL =
        ((SCALE_FULL << OUT_FRAC_BITS) > OUT_MAX) ? OUT_MAX : (SCALE_FULL << OUT_FRAC_BITS);
    localparam logic [63:0] CAP_UNIT =
        ((SCALE_UNIT << OUT_FRAC_BITS) > OUT_MAX) ? OUT_MAX : (SCALE_UNIT << OUT_FRAC_BITS);
    localparam logic [63:0] OUT_HALF = 64'd1 << (31 - OUT_FRAC_BITS);

    logic               r_vld [4];
    logic signed [VEC_W-1:0] w_c [4];
    logic [63:0]        r_sq [4];
    logic [35:0]        r_m  [2];
    logic [63:0]        r_t  [2];
    logic [29:0]        r_out [2];
    logic [63:0]        w_scale, w_cap;

    assign w_c[0] = i_vec.ar;
    assign w_c[1] = i_vec.ai;
    assign w_c[2] = i_vec.br;
    assign w_c[3] = i_vec.bi;
    assign w_scale = i_mode ? SCALE_FULL : SCALE_UNIT;
    assign w_cap   = i_mode ? CAP_FULL : CAP_UNIT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) r_vld[i] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
            for (int i = 1; i < 4; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    // Square the magnitudes
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            logic [VEC_W-1:0] u;
            u = (w_c[i] < 0) ? VEC_W'(-w_c[i]) : VEC_W'(w_c[i]);
            r_sq[i] <= 64'(u[31:0]) * 64'(u[31:0]);
        end
    end

    // Add and round to Q.32, apply scale, round to output fraction and cap
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 2; j++) begin
            logic [63:0] pw, o;
            pw = r_sq[2*j] + r_sq[2*j+1] + 64'd134217728;
            r_m[j] <= pw[63:28];
            r_t[j] <= 64'(r_m[j]) * w_scale;
            o = (r_t[j] + OUT_HALF) >> (32 - OUT_FRAC_BITS);
            r_out[j] <= (o > w_cap) ? w_cap[29:0] : o[29:0];
        end
    end

    assign o_vld                       = r_vld[3];
    assign o_item.horizontal_intensity = r_out[0];
    assign o_item.vertical_intensity   = r_out[1];

endmodule

FILE: sv/waveplate_chain_intensity.sv
// Jones-calculus chain of four waveplates, fully pipelined.
// The path from the accepting edge to the cycle with o_strobe runs through
// 43 register stages: 31 CORDIC, 2 per plate, 4 in the intensity unit.
// Throughput: one word per cycle; busy is never raised and the result is not held.
// Reset (synchronous, active low) clears scan_mode to 0 and all stage valid bits.
module waveplate_chain_intensity
    import wpc_pkg::*;
#(
    parameter int ANGLE_BITS    = 16,
    parameter int OUT_FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data,
    output logic      o_strobe,
    output t_out_item o_result
);

    logic        r_scan_mode;
    logic [15:0] w_ang [4];
    logic        w_cvld [4];
    t_cs         w_cs [4];
    t_cs         w_cse [4];
    t_cs         w_csd [4];
    logic        w_pvld [5];
    t_vec        w_pvec [5];

    assign busy = 1'b0;

    // Hold the mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_scan_mode <= i_cfg_data;
        end
    end

    assign w_ang[0] = i_item.half_plate_a_angle;
    assign w_ang[1] = i_item.quarter_plate_a_angle;
    assign w_ang[2] = i_item.half_plate_b_angle;
    assign w_ang[3] = i_item.quarter_plate_b_angle;

    // Sine and cosine of all four plates in parallel
    for (genvar k = 0; k < 4; k++) begin : g_cordic
        wpc_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (start),
            .i_angle (w_ang[k]),
            .o_vld   (w_cvld[k]),
            .o_cs    (w_cs[k])
        );
        // Turn the plate the other way in mode 0
        assign w_cse[k].c = w_cs[k].c;
        assign w_cse[k].s = r_scan_mode ? w_cs[k].s : -w_cs[k].s;
    end

    // Delay each plate's coefficients to meet the vector
    assign w_csd[0] = w_cse[0];
    for (genvar k = 1; k < 4; k++) begin : g_dly
        t_cs r_dly [2*k];
        always_ff @(posedge i_clk) begin
            r_dly[0] <= w_cse[k];
            for (int i = 1; i < 2 * k; i++) r_dly[i] <= r_dly[i-1];
        end
        assign w_csd[k] = r_dly[2*k-1];
    end

    // Horizontal unit input
    assign w_pvld[0]    = w_cvld[0];
    assign w_pvec[0].ar = VEC_W'(Q30_ONE);
    assign w_pvec[0].ai = '0;
    assign w_pvec[0].br = '0;
    assign w_pvec[0].bi = '0;

    for (genvar k = 0; k < 4; k++) begin : g_plate
        if (k % 2 == 0) begin : g_half
            wpc_half_plate u_plate (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_vld   (w_pvld[k]),
                .i_cs    (w_csd[k]),
                .i_vec   (w_pvec[k]),
                .o_vld   (w_pvld[k+1]),
                .o_vec   (w_pvec[k+1])
            );
        end else begin : g_quarter
            wpc_quarter_plate u_plate (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_vld   (w_pvld[k]),
                .i_cs    (w_csd[k]),
                .i_vec   (w_pvec[k]),
                .o_vld   (w_pvld[k+1]),
                .o_vec   (w_pvec[k+1])
            );
        end
    end

    wpc_intensity #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_intensity (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_pvld[4]),
        .i_mode  (r_scan_mode),
        .i_vec   (w_pvec[4]),
        .o_vld   (o_strobe),
        .o_item  (o_result)
    );

endmodule
